// ===== hdl/rss_pkg.sv =====
// running sample statistics: shared types and constants
// no dependencies; used by rss_front, rss_back and the top level
package rss_pkg;

  // one classified transaction passed from the front to the back part
  typedef struct packed {
    logic        clear;
    logic [15:0] sample;
  } rss_cmd_t;

  localparam int QueueDepth = 2;

endpackage

// ===== hdl/rss_front.sv =====
// running sample statistics: input stage and two-entry command queue
// depends on rss_pkg
module rss_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_command,
  input  logic [15:0]       in_sample,
  input  logic              cmd_take,
  output logic              cmd_avail,
  output rss_pkg::rss_cmd_t cmd_head
);

  rss_pkg::rss_cmd_t q_r [rss_pkg::QueueDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push_ok;
  rss_pkg::rss_cmd_t cmd_in;

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign cmd_avail = (cnt_r != 2'd0);
  assign cmd_head  = q_r[rd_r];

  // count-full condition is resolved in the back part against live state
  always_comb begin
    cmd_in.clear  = in_command;
    cmd_in.sample = {{(16-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}},
                     in_sample[SAMPLE_BITS-1:0]};
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, cmd_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wr_r <= ~wr_r;
      if (cmd_take) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wr_r] <= cmd_in;
  end

endmodule

// ===== hdl/rss_div.sv =====
// running sample statistics: restoring unsigned divider, one bit per cycle
// depends on nothing
module rss_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [23:0] den,
  output logic        busy,
  output logic [63:0] quo
);

  logic [63:0] q_r;
  logic [24:0] rem_r;
  logic [6:0]  step_r;
  logic [23:0] den_r;
  logic [24:0] trial;
  logic        ge;

  assign busy = (step_r != 7'd0);
  assign quo  = q_r;
  assign trial = {rem_r[23:0], q_r[63]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 7'd0;
    end else if (start) begin
      step_r <= 7'd64;
    end else if (busy) begin
      step_r <= step_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      rem_r <= ge ? trial - {1'b0, den_r} : trial;
      q_r   <= {q_r[62:0], ge};
    end
  end

endmodule

// ===== hdl/rss_sqrt.sv =====
// running sample statistics: digit-by-digit integer square root
// depends on nothing
module rss_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] v_r, res_r, bit_r;
  logic [5:0]  step_r;
  logic [63:0] sum;

  assign busy = (step_r != 6'd0);
  assign root = res_r[31:0];
  assign sum  = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 6'd0;
    end else if (start) begin
      step_r <= 6'd32;
    end else if (busy) begin
      step_r <= step_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= val;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (v_r >= sum) begin
        v_r   <= v_r - sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

// ===== hdl/rss_back.sv =====
// running sample statistics: accumulators and result sequencer
// depends on rss_pkg, rss_div, rss_sqrt
module rss_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_avail,
  input  rss_pkg::rss_cmd_t cmd_head,
  output logic              cmd_take,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [23:0]       out_sample_count,
  output logic [15:0]       out_mean_value,
  output logic [15:0]       out_deviation,
  output logic [15:0]       out_minimum,
  output logic [15:0]       out_maximum,
  output logic [15:0]       out_mean_step,
  output logic [15:0]       out_step_deviation,
  output logic              out_full_res
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MUL1  = 10'b00_0000_0010,
    S_DIV1  = 10'b00_0000_0100,
    S_MUL2  = 10'b00_0000_1000,
    S_DIV2  = 10'b00_0001_0000,
    S_SQRT2 = 10'b00_0010_0000,
    S_DIVS  = 10'b00_0100_0000,
    S_MULS  = 10'b00_1000_0000,
    S_DIVS2 = 10'b01_0000_0000,
    S_SQRTS = 10'b10_0000_0000
  } st_t;

  localparam logic [COUNT_BITS-1:0] CntFull = '1;
  localparam logic signed [15:0] SMax = 16'((1 << (SAMPLE_BITS-1)) - 1);

  st_t st_r;
  logic [23:0] count_r;
  logic signed [39:0] total_r;
  logic [55:0] sq_r;
  logic signed [15:0] min_r, max_r, last_r;
  logic [39:0] stot_r;
  logic [55:0] ssq_r;
  logic out_v_r;
  logic full_r;
  logic [15:0] mean_r, dev_r, mstep_r, sdev_r;
  logic [63:0] mag_r, t_r;
  logic neg_r;
  logic [23:0] n1;
  logic [55:0] scaled;

  logic div_go, sq_go, div_busy, sq_busy;
  logic [63:0] div_num, div_q, sq_val;
  logic [23:0] div_den;
  logic [31:0] sq_root;
  logic waiting_r;

  rss_div u_div (.clk, .rst_n, .start(div_go), .num(div_num), .den(div_den),
                 .busy(div_busy), .quo(div_q));
  rss_sqrt u_sqrt (.clk, .rst_n, .start(sq_go), .val(sq_val), .busy(sq_busy),
                   .root(sq_root));

  logic signed [16:0] d;
  logic [15:0] ad;
  logic signed [15:0] s;
  logic [COUNT_BITS-1:0] cnt_lo;

  assign s      = $signed(cmd_head.sample);
  assign cnt_lo = count_r[COUNT_BITS-1:0];
  assign n1     = count_r - 24'd1;
  assign d      = 17'(s) - 17'(last_r);
  assign ad     = d[16] ? 16'(-d) : d[15:0];
  assign cmd_take = (st_r == S_IDLE) && cmd_avail && !out_v_r;

  // squared mean (at most 32 bits) times the sample or step count
  assign scaled = mag_r[31:0] * ((st_r == S_MULS) ? n1 : count_r);

  assign out_empty          = !out_v_r;
  assign out_sample_count   = count_r;
  assign out_mean_value     = mean_r;
  assign out_deviation      = dev_r;
  assign out_minimum        = min_r;
  assign out_maximum        = max_r;
  assign out_mean_step      = mstep_r;
  assign out_step_deviation = sdev_r;
  assign out_full_res       = full_r;

  // unit start strobes: fire on the first cycle of a state
  always_comb begin
    div_go  = 1'b0;
    sq_go   = 1'b0;
    div_den = count_r;
    sq_val  = t_r;
    if (!waiting_r) begin
      case (st_r)
        S_DIV1:  div_go = 1'b1;
        S_DIV2:  div_go = 1'b1;
        S_SQRT2: sq_go  = 1'b1;
        S_DIVS:  begin div_go = 1'b1; div_den = n1; end
        S_DIVS2: begin div_go = 1'b1; div_den = n1; end
        S_SQRTS: sq_go  = 1'b1;
        default: ;
      endcase
    end
    if (st_r == S_DIVS2 || st_r == S_DIVS) div_den = n1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_v_r <= 1'b0; waiting_r <= 1'b0;
      count_r <= '0; total_r <= '0; sq_r <= '0; stot_r <= '0; ssq_r <= '0;
      min_r <= SMax; max_r <= ~SMax; last_r <= '0; full_r <= 1'b0;
    end else begin
      if (out_pop && out_v_r) out_v_r <= 1'b0;
      case (st_r)
        S_IDLE: if (cmd_take) begin
          full_r <= 1'b0;
          if (cmd_head.clear) begin
            count_r <= '0; total_r <= '0; sq_r <= '0; stot_r <= '0;
            ssq_r <= '0; min_r <= SMax; max_r <= ~SMax; last_r <= '0;
          end else if (cnt_lo == CntFull) begin
            full_r <= 1'b1;
          end else begin
            count_r <= count_r + 24'd1;
            total_r <= total_r + 40'(s);
            sq_r    <= sq_r + 56'(32'(s) * 32'(s));
            if (s < min_r) min_r <= s;
            if (s > max_r) max_r <= s;
            if (count_r != 24'd0) begin
              stot_r <= stot_r + 40'(ad);
              ssq_r  <= ssq_r + 56'(32'(ad) * 32'(ad));
            end
            last_r <= s;
          end
          st_r <= S_MUL1;
        end
        S_MUL1: begin
          neg_r <= total_r[39];
          mag_r <= 64'(total_r[39] ? -total_r : total_r);
          mean_r <= '0; dev_r <= '0; mstep_r <= '0; sdev_r <= '0;
          st_r  <= (count_r == 24'd0) ? S_IDLE : S_DIV1;
          if (count_r == 24'd0) out_v_r <= 1'b1;
        end
        S_DIV1: if (!waiting_r) waiting_r <= 1'b1;
          else if (!div_busy) begin
            waiting_r <= 1'b0;
            mean_r <= neg_r ? 16'(-div_q) : div_q[15:0];
            mag_r  <= 64'({16'd0, div_q[15:0]} * {16'd0, div_q[15:0]});
            st_r   <= S_MUL2;
          end
        S_MUL2: begin
          t_r  <= 64'(scaled);
          st_r <= S_DIV2;
        end
        S_DIV2: if (!waiting_r) begin
            waiting_r <= 1'b1;
          end else if (!div_busy) begin
            waiting_r <= 1'b0;
            t_r  <= div_q;
            st_r <= S_SQRT2;
          end
        S_SQRT2: if (!waiting_r) begin
            waiting_r <= 1'b1;
          end else if (!sq_busy) begin
            waiting_r <= 1'b0;
            dev_r <= sq_root[15:0];
            mag_r <= 64'(stot_r);
            if (count_r > 24'd1) st_r <= S_DIVS;
            else begin st_r <= S_IDLE; out_v_r <= 1'b1; end
          end
        S_DIVS: if (!waiting_r) waiting_r <= 1'b1;
          else if (!div_busy) begin
            waiting_r <= 1'b0;
            mstep_r <= div_q[15:0];
            mag_r   <= 64'({16'd0, div_q[15:0]} * {16'd0, div_q[15:0]});
            st_r    <= S_MULS;
          end
        S_MULS: begin
          t_r  <= 64'(scaled);
          st_r <= S_DIVS2;
        end
        S_DIVS2: if (!waiting_r) begin
            waiting_r <= 1'b1;
          end else if (!div_busy) begin
            waiting_r <= 1'b0;
            t_r  <= div_q;
            st_r <= S_SQRTS;
          end
        S_SQRTS: if (!waiting_r) begin
            waiting_r <= 1'b1;
          end else if (!sq_busy) begin
            waiting_r <= 1'b0;
            sdev_r <= sq_root[15:0];
            st_r <= S_IDLE; out_v_r <= 1'b1;
          end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // variance numerators are formed when the divide is launched
  always_comb begin
    if (st_r == S_DIV2 || st_r == S_DIVS2) begin
      if (st_r == S_DIV2)
        div_num = (t_r > 64'(sq_r)) ? 64'd0 : 64'(sq_r) - t_r;
      else
        div_num = (t_r > 64'(ssq_r)) ? 64'd0 : 64'(ssq_r) - t_r;
    end else begin
      div_num = mag_r;
    end
  end

endmodule

// ===== hdl/running_sample_statistics_unit.sv =====
// running sample statistics unit: top level
// depends on rss_pkg, rss_front, rss_back (rss_div, rss_sqrt)
// with two or more samples held a result takes four divides on one radix-2 divider and
//   two roots on one root unit; a single sample takes two divides and one root, and a
//   clear or an empty result takes no divide or root
// only one transaction is in flight; the next one starts after its result is popped
// reset: synchronous active-low rst_n; statistics return to empty, queue empties
module running_sample_statistics_unit #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_command,
  input  logic [15:0] in_sample,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [23:0] out_sample_count,
  output logic [15:0] out_mean_value,
  output logic [15:0] out_deviation,
  output logic [15:0] out_minimum,
  output logic [15:0] out_maximum,
  output logic [15:0] out_mean_step,
  output logic [15:0] out_step_deviation,
  output logic        out_full_res
);

  // front-to-back command channel
  logic              cmd_take, cmd_avail;
  rss_pkg::rss_cmd_t cmd_head;

  rss_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_command, .in_sample,
    .cmd_take, .cmd_avail, .cmd_head
  );

  // back part holds the statistics and sequences the shared math units
  rss_back #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .cmd_avail, .cmd_head, .cmd_take, .out_empty, .out_pop,
    .out_sample_count, .out_mean_value, .out_deviation, .out_minimum,
    .out_maximum, .out_mean_step, .out_step_deviation, .out_full_res
  );

  // a queue entry is only taken while the queue holds one (and the back part is free)
  a_take_avail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_avail) else $error("command taken from empty queue");

  // the full flag only comes with saturated, hence nonempty, statistics
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_full_res) |-> (out_sample_count != 24'd0))
    else $error("full flag with empty statistics");

endmodule

// ===== tb/running_sample_statistics_unit_tb.sv =====
// running sample statistics unit: self-checking testbench
// depends on running_sample_statistics_unit; predicts results in-line, typed rows carry their own
module running_sample_statistics_unit_tb;

  localparam int SampleMax = 32767;
  localparam int SampleMin = -32768;
  localparam int CountFull = (1 << 24) - 1;
  localparam int RandomItems = 1530;
  localparam int HoldCycles = 1500;
  localparam int WatchdogLimit = 6000;
  localparam int TailCycles = 400;

  typedef enum logic {CMD_ADD = 1'b0, CMD_CLEAR = 1'b1} stat_cmd_e;

  typedef struct {
    logic [23:0] count;
    logic [15:0] mean;
    logic [15:0] dev;
    logic [15:0] min;
    logic [15:0] max;
    logic [15:0] step_mean;
    logic [15:0] step_dev;
    logic        full;
  } stats_t;

  // one row of the directed table; typed rows carry their result
  typedef struct {
    stat_cmd_e   cmd;
    logic [15:0] sample;
    bit          typed;
    stats_t      res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_command = 1'b0;
  logic [15:0] in_sample = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [23:0] out_sample_count;
  logic [15:0] out_mean_value;
  logic [15:0] out_deviation;
  logic [15:0] out_minimum;
  logic [15:0] out_maximum;
  logic [15:0] out_mean_step;
  logic [15:0] out_step_deviation;
  logic        out_full_res;

  // predictor state
  int unsigned        n_samples;
  longint             sum;
  longint unsigned    sum_sq;
  int                 lo_sample;
  int                 hi_sample;
  int                 prev_sample;
  longint unsigned    step_sum;
  longint unsigned    step_sum_sq;

  stats_t pending_stats[$];
  int errors = 0;
  int in_xact = 0;
  int out_xact = 0;
  int clears_sent = 0;
  bit hold_req = 1'b0;
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  running_sample_statistics_unit dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // floor(sqrt((sq - n*m*m)/n)), zero when undefined
  function automatic longint unsigned spread(longint unsigned sq, longint unsigned n,
                                             longint unsigned m);
    longint unsigned sub = n * m * m;
    if (n == 0 || sub > sq) return 0;
    return int_sqrt((sq - sub) / n);
  endfunction

  function automatic void clear_stats();
    n_samples = 0;
    sum = 0;
    sum_sq = 0;
    lo_sample = SampleMax;
    hi_sample = SampleMin;
    prev_sample = 0;
    step_sum = 0;
    step_sum_sq = 0;
  endfunction

  // advance the running statistics by one transaction and report them
  function automatic stats_t update_stats(stat_cmd_e cmd, logic [15:0] raw);
    stats_t r;
    longint s = longint'($signed(raw));
    longint d;
    longint mean = 0;
    longint unsigned ad;
    longint unsigned n1;
    longint unsigned mstep = 0;
    bit full = 1'b0;
    if (cmd == CMD_CLEAR) begin
      clear_stats();
    end else if (n_samples >= CountFull) begin
      full = 1'b1;
    end else begin
      n_samples++;
      sum += s;
      sum_sq += longint'(s * s);
      if (s < lo_sample) lo_sample = int'(s);
      if (s > hi_sample) hi_sample = int'(s);
      if (n_samples > 1) begin
        d = s - prev_sample;
        ad = (d < 0) ? -d : d;
        step_sum += ad;
        step_sum_sq += ad * ad;
      end
      prev_sample = int'(s);
    end
    r.count = n_samples[23:0];
    r.dev = '0;
    r.step_mean = '0;
    r.step_dev = '0;
    if (n_samples > 0) begin
      mean = sum / longint'(n_samples);
      r.dev = 16'(spread(sum_sq, n_samples, (mean < 0) ? -mean : mean));
    end
    if (n_samples > 1) begin
      n1 = n_samples - 1;
      mstep = step_sum / n1;
      r.step_mean = 16'(mstep);
      r.step_dev = 16'(spread(step_sum_sq, n1, mstep));
    end
    r.mean = 16'(mean);
    r.min = 16'(lo_sample);
    r.max = 16'(hi_sample);
    r.full = full;
    return r;
  endfunction

  // offer one transaction until taken; returns the predicted result
  task automatic push_item(stat_cmd_e cmd, logic [15:0] smp, output stats_t r);
    in_command <= cmd;
    in_sample <= smp;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    in_xact++;
    r = update_stats(cmd, smp);
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result side: compare each popped transaction with the oldest prediction
  always @(posedge clk) begin
    stats_t e;
    if (rst_n && out_pop && !out_empty) begin
      out_xact++;
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, actual count %0d",
                 $time, out_sample_count);
      end else begin
        e = pending_stats.pop_front();
        check_field("sample_count", e.count, out_sample_count);
        check_field("mean_value", e.mean, out_mean_value);
        check_field("deviation", e.dev, out_deviation);
        check_field("minimum", e.min, out_minimum);
        check_field("maximum", e.max, out_maximum);
        check_field("mean_step", e.step_mean, out_mean_step);
        check_field("step_deviation", e.step_dev, out_step_deviation);
        check_field("full_res", e.full, out_full_res);
      end
    end
  end

  // watchdog: cycles without any transaction on either side
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || stim_done) begin
      quiet = 0;
    end else if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("watchdog expired at %0t with %0d results pending", $time,
                 pending_stats.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    stats_t r;
    stats_t empty_stats;
    logic [15:0] smp;
    int pick;
    int wait_cnt;

    empty_stats = '{count: 24'd0, mean: 16'd0, dev: 16'd0, min: 16'h7fff, max: 16'h8000,
                    step_mean: 16'd0, step_dev: 16'd0, full: 1'b0};

    // directed table: clear with junk sample, extremes, single sample, sign edges
    rows.push_back('{CMD_CLEAR, 16'hffff, 1, empty_stats});
    rows.push_back('{CMD_ADD, 16'h7fff, 1, '{24'd1, 16'h7fff, 16'd0, 16'h7fff, 16'h7fff,
                     16'd0, 16'd0, 1'b0}});
    rows.push_back('{CMD_ADD, 16'h8000, 1, '{24'd2, 16'd0, 16'd32767, 16'h8000, 16'h7fff,
                     16'd65535, 16'd0, 1'b0}});
    rows.push_back('{CMD_ADD, 16'h7fff, 0, empty_stats});
    rows.push_back('{CMD_ADD, 16'h8000, 0, empty_stats});
    rows.push_back('{CMD_CLEAR, 16'h1234, 1, empty_stats});
    rows.push_back('{CMD_ADD, 16'h8000, 1, '{24'd1, 16'h8000, 16'd0, 16'h8000, 16'h8000,
                     16'd0, 16'd0, 1'b0}});
    rows.push_back('{CMD_ADD, 16'h8000, 0, empty_stats});
    rows.push_back('{CMD_ADD, 16'hffff, 0, empty_stats});
    rows.push_back('{CMD_ADD, 16'h0001, 0, empty_stats});
    rows.push_back('{CMD_ADD, 16'h0000, 0, empty_stats});
    rows.push_back('{CMD_CLEAR, 16'h0000, 1, empty_stats});
    rows.push_back('{CMD_ADD, 16'h0000, 1, '{24'd1, 16'd0, 16'd0, 16'd0, 16'd0,
                     16'd0, 16'd0, 1'b0}});
    rows.push_back('{CMD_ADD, 16'h0000, 0, empty_stats});
    rows.push_back('{CMD_ADD, 16'h5555, 0, empty_stats});
    rows.push_back('{CMD_ADD, 16'haaaa, 0, empty_stats});
    rows.push_back('{CMD_ADD, 16'hffff, 0, empty_stats});
    rows.push_back('{CMD_ADD, 16'h0001, 0, empty_stats});
    rows.push_back('{CMD_CLEAR, 16'hffff, 1, empty_stats});
    rows.push_back('{CMD_CLEAR, 16'h0000, 1, empty_stats});

    clear_stats();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      push_item(row.cmd, row.sample, r);
      pending_stats.push_back(row.typed ? row.res : r);
      sender_gap();
    end

    for (int i = 0; i < RandomItems; i++) begin
      // receiver holds off while the sender keeps offering
      if (i == 300) hold_req = 1'b1;
      // sender pauses until every pending result has drained
      if (i == 700) begin
        in_push <= 1'b0;
        wait (pending_stats.size() == 0);
        @(posedge clk);
      end
      if (i == RandomItems - 150) calm = 1'b1;
      pick = $urandom_range(0, 99);
      case (1)
        pick < 30: smp = $urandom_range(0, 65535);
        pick < 60: smp = 16'($signed(16'($urandom_range(0, 200))) - 16'sd100);
        pick < 75: smp = $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 15))
                                              : 16'h8000 + 16'($urandom_range(0, 15));
        default:   smp = 16'(1000 + $urandom_range(0, 2000));
      endcase
      if ($urandom_range(0, 39) == 0) begin
        push_item(CMD_CLEAR, 16'($urandom_range(0, 65535)), r);
      end else begin
        push_item(CMD_ADD, smp, r);
      end
      pending_stats.push_back(r);
      sender_gap();
    end
    in_push <= 1'b0;

    wait_cnt = 0;
    while (pending_stats.size() != 0 && wait_cnt < WatchdogLimit * 4) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (TailCycles) @(posedge clk);
    stim_done = 1'b1;

    $display("covered %0d transactions in, %0d results out, %0d clears, extremes and",
             in_xact, out_xact, clears_sent);
    $display("long receiver hold-off plus sender drain pause");
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== running_sample_statistics_unit.f =====
hdl/rss_pkg.sv
hdl/rss_front.sv
hdl/rss_div.sv
hdl/rss_sqrt.sv
hdl/rss_back.sv
hdl/running_sample_statistics_unit.sv
tb/running_sample_statistics_unit_tb.sv
